// ----- hw/rtl/stach_pkg.sv -----
// Package for the song text access code hash core.
// Holds the item types, the queue head struct, mask constants and the id shuffle.
// No dependencies.
`default_nettype none

package stach_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [31:0] BYTE0_MASK = 32'h0000_00FF;
   localparam logic [31:0] BYTE1_MASK = 32'h0000_FF00;
   localparam logic [31:0] BYTE2_MASK = 32'h00FF_0000;
   localparam logic [31:0] BYTE3_MASK = 32'hFF00_0000;
   localparam logic [31:0] WORD_MASK  = 32'hFFFF_FFFF;

   typedef enum logic [0:0] {
      OP_TEXT   = 1'b0,
      OP_FINISH = 1'b1
   } stach_op_type;

   typedef struct packed {
      stach_op_type op;
      logic [7:0]   text_byte;
      logic [31:0]  song_id;
   } stach_item_type;

   typedef struct packed {
      logic           valid;
      stach_item_type item;
   } stach_head_type;

   // Byte shuffle of the song id; a zero upper byte is replaced by the
   // complement of its partner byte.
   function automatic logic [31:0] shuffle_id(input logic [31:0] id);
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [7:0] b3;
      logic [7:0] b2x;
      logic [7:0] b3x;
      b0  = 8'((id & BYTE0_MASK) >> 0);
      b1  = 8'((id & BYTE1_MASK) >> 8);
      b2  = 8'((id & BYTE2_MASK) >> 16);
      b3  = 8'((id & BYTE3_MASK) >> 24);
      b2x = (b2 == 8'h00) ? ~b1 : b2;
      b3x = (b3 == 8'h00) ? ~b0 : b3;
      return ({b0, b2x, b1, b3x} & WORD_MASK);
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/song_text_access_code_hash_core.sv -----
// Song text access code hash core. Text bytes (artist, then title) are sent
// with mode 0 and give no result; a finish item (mode 1) carries the song id
// and gives one signed 32-bit access code, after which the sums start over.
// The back end folds a text item in ST_RUN with its single byte-by-word
// multiply; a finish item passes through ST_RUN, ST_MUL1 and ST_MUL2 for the
// two dependent 32x32 multiplies of the mix. A two-entry queue sits between
// the input and the back end, and the result waits in an output register,
// so input is taken while a code is still held by a stalled receiver.
`default_nettype none

module song_text_access_code_hash_core import stach_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire logic           req_mode,
   input  wire logic [7:0]     req_text_byte,
   input  wire logic signed [31:0] req_song_id,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output logic signed [31:0]  rsp_code_value
);

   stach_head_type head;
   logic           pop;
   logic [31:0]    code_value;

   stach_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_mode      (req_mode),
      .req_text_byte (req_text_byte),
      .req_song_id   (32'(unsigned'(req_song_id))),
      .head          (head),
      .pop           (pop)
   );

   stach_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_value (code_value)
   );

   assign rsp_code_value = signed'(code_value);

endmodule

`default_nettype wire

// ----- hw/rtl/stach_front.sv -----
// Front end of the access code hash: accepts items, classifies them and
// buffers them in a short queue for the back end. Depends on stach_pkg.
`default_nettype none

module stach_front import stach_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_stall,
   input  wire logic           req_mode,
   input  wire logic [7:0]     req_text_byte,
   input  wire logic [31:0]    req_song_id,
   output stach_head_type      head,
   input  wire logic           pop
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   stach_item_type slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   stach_item_type   item;
   logic             push;
   logic             do_pop;

   always_comb begin
      item.op        = req_mode ? OP_FINISH : OP_TEXT;
      // Fields that the operation ignores are zeroed so the queue holds clean data.
      item.text_byte = req_mode ? 8'h00 : req_text_byte;
      item.song_id   = req_mode ? req_song_id : 32'h0000_0000;
   end

   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ----- hw/rtl/stach_back.sv -----
// Back end of the access code hash: folds text items into the running sums
// and runs the finish mix through ST_MUL1 and ST_MUL2. Depends on stach_pkg.
`default_nettype none

module stach_back import stach_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire stach_head_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  wire logic           rsp_stall,
   output logic [31:0]         rsp_code_value
);

   typedef enum logic [2:0] {
      ST_RUN  = 3'b001,
      ST_MUL1 = 3'b010,
      ST_MUL2 = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] fwd_ff, fwd_in;
   logic [31:0] rev_ff, rev_in;
   logic [31:0] weight_ff, weight_in;
   logic        parity_ff, parity_in;
   logic [31:0] v_ff, v_in;
   logic [31:0] m1_ff, m1_in;
   logic [31:0] m2_ff, m2_in;
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_value_ff, out_value_in;

   logic [31:0] c;
   logic [31:0] sh;
   logic [31:0] id;
   logic        out_free;

   assign id       = head.item.song_id;
   assign c        = {{24{head.item.text_byte[7]}}, head.item.text_byte};
   assign sh       = shuffle_id(id);
   assign out_free = !out_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      fwd_in       = fwd_ff;
      rev_in       = rev_ff;
      weight_in    = weight_ff;
      parity_in    = parity_ff;
      v_in         = v_ff;
      m1_in        = m1_ff;
      m2_in        = m2_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_value_in = out_value_ff;
      pop          = 1'b0;
      case (state_ff)
         ST_RUN: begin
            if (head.valid) begin
               pop = 1'b1;
               if (head.item.op == OP_TEXT) begin
                  // Multipliers 1+2^(3+p) and 1+2^(4+p) reduce to a shift and add.
                  fwd_in    = fwd_ff + (parity_ff ? (fwd_ff << 4) : (fwd_ff << 3)) + c;
                  rev_in    = rev_ff + c * weight_ff;
                  weight_in = weight_ff +
                              (parity_ff ? (weight_ff << 5) : (weight_ff << 4));
                  parity_in = !parity_ff;
               end else begin
                  v_in      = (rev_ff ^ sh) + (fwd_ff | id);
                  m1_in     = fwd_ff | sh;
                  m2_in     = rev_ff ^ id;
                  fwd_in    = 32'h0000_0000;
                  rev_in    = 32'h0000_0000;
                  weight_in = 32'h0000_0001;
                  parity_in = 1'b0;
                  state_in  = ST_MUL1;
               end
            end
         end
         ST_MUL1: begin
            v_in     = v_ff * m1_ff;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            if (out_free) begin
               out_value_in = v_ff * m2_ff;
               out_valid_in = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         fwd_ff       <= 32'h0000_0000;
         rev_ff       <= 32'h0000_0000;
         weight_ff    <= 32'h0000_0001;
         parity_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fwd_ff       <= fwd_in;
         rev_ff       <= rev_in;
         weight_ff    <= weight_in;
         parity_ff    <= parity_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff         <= v_in;
      m1_ff        <= m1_in;
      m2_ff        <= m2_in;
      out_value_ff <= out_value_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_value = out_value_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/stach_checker.sv -----
// Port-level checks for the song text access code hash core, with the bind
// that attaches them to the top level. Depends on the top level's ports only.
`default_nettype none

module stach_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [31:0] rsp_code_value
);

   // A held code must stay put until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_value))
      else $error("access code changed or dropped while stalled");

   // Reset empties the output register.
   a_reset_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Reset empties the queue, so input is open at once.
   a_reset_req: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("input stalled right after reset");

   // A finish passes through the queue, ST_RUN, ST_MUL1 and ST_MUL2 before its code
   // is registered, so a fresh code never appears right after a reset cycle and an empty queue.
   a_no_early_rsp: assert property (@(posedge clock)
      reset ##1 !(req_valid && !req_stall) |=> !rsp_valid)
      else $error("result appeared without a finish item");

endmodule

bind song_text_access_code_hash_core stach_checker u_stach_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_code_value (rsp_code_value)
);

`default_nettype wire

// ----- dv/song_text_access_code_hash_checker.sv -----
// Checker for the song text access code hash core: watches both channels,
// folds accepted text items into its own sums and compares every access code.
// Depends on stach_pkg for the item op codes.
`timescale 1ns / 100ps

module song_text_access_code_hash_checker import stach_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic               req_mode,
   input  logic [7:0]         req_text_byte,
   input  logic signed [31:0] req_song_id,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_code_value,
   output int                 fail_count,
   output int                 codes_checked,
   output int                 codes_pending
);

   localparam int PRINT_LIMIT = 20;

   logic [31:0] fwd_hash;
   logic [31:0] rev_hash;
   logic [31:0] rev_weight;
   logic        odd_pos;
   logic [31:0] expected_codes[$];
   logic [31:0] want_code;

   initial begin
      fail_count    = 0;
      codes_checked = 0;
      codes_pending = 0;
   end

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) begin
         $display("%0t checker: %s", $time, what);
      end
   endtask

   // A zero upper byte of the id is replaced by the complement of the byte
   // it is paired with.
   function automatic logic [31:0] shuffled_id_word(input logic [31:0] id);
      logic [7:0] hi_x;
      logic [7:0] mid_x;
      mid_x = (id[23:16] == 8'h00) ? ~id[15:8] : id[23:16];
      hi_x  = (id[31:24] == 8'h00) ? ~id[7:0]  : id[31:24];
      return {id[7:0], mid_x, id[15:8], hi_x};
   endfunction

   function automatic logic [31:0] access_code_of(input logic [31:0] fwd,
                                                  input logic [31:0] rev,
                                                  input logic [31:0] id);
      logic [31:0] sh;
      logic [31:0] v;
      sh = shuffled_id_word(id);
      v  = rev ^ sh;
      v  = v + (fwd | id);
      v  = v * (fwd | sh);
      v  = v * (rev ^ id);
      return v;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fwd_hash   = 32'd0;
         rev_hash   = 32'd0;
         rev_weight = 32'd1;
         odd_pos    = 1'b0;
         expected_codes.delete();
         codes_pending <= 0;
      end else begin
         // Results first: a code never belongs to a finish taken at the same edge.
         if (rsp_valid && !rsp_stall) begin
            if (expected_codes.size() == 0) begin
               report_mismatch($sformatf("code %h with no finish item waiting",
                                         rsp_code_value));
            end else begin
               want_code = expected_codes.pop_front();
               codes_checked++;
               if (rsp_code_value !== want_code) begin
                  report_mismatch($sformatf("code_value %h, expected %h",
                                            rsp_code_value, want_code));
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (stach_op_type'(req_mode) == OP_FINISH) begin
               expected_codes.push_back(access_code_of(fwd_hash, rev_hash, req_song_id));
               fwd_hash   = 32'd0;
               rev_hash   = 32'd0;
               rev_weight = 32'd1;
               odd_pos    = 1'b0;
            end else begin
               // The byte counts as signed; multipliers are 1+2^3 / 1+2^4 on even
               // positions and 1+2^4 / 1+2^5 on odd ones.
               fwd_hash   = fwd_hash * (odd_pos ? 32'd17 : 32'd9)
                            + {{24{req_text_byte[7]}}, req_text_byte};
               rev_hash   = rev_hash + {{24{req_text_byte[7]}}, req_text_byte} * rev_weight;
               rev_weight = rev_weight * (odd_pos ? 32'd33 : 32'd17);
               odd_pos    = ~odd_pos;
            end
         end
         codes_pending <= expected_codes.size();
      end
   end

endmodule

// ----- dv/tb_song_text_access_code_hash_core.sv -----
// Testbench top for the song text access code hash core: clock, reset,
// directed and random song text messages, receiver stalls and the verdict.
// Depends on stach_pkg, the core and song_text_access_code_hash_checker.
`timescale 1ns / 100ps

module tb_song_text_access_code_hash_core import stach_pkg::*; ;

   // Longest legal quiet stretch is the receiver hold-off plus a long gap.
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 4000;
   localparam int PHASE_ITEMS  = 250;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_mode;
   logic [7:0]         req_text_byte;
   logic signed [31:0] req_song_id;
   logic               rsp_stall;
   wire                req_stall;
   wire                rsp_valid;
   wire signed [31:0]  rsp_code_value;

   int fail_count;
   int codes_checked;
   int codes_pending;
   int items_sent;
   int messages_sent;
   int sender_idle_pct;
   int quiet_cycles;
   bit hold_off_request;

   song_text_access_code_hash_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_text_byte  (req_text_byte),
      .req_song_id    (req_song_id),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_value (rsp_code_value)
   );

   song_text_access_code_hash_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_text_byte  (req_text_byte),
      .req_song_id    (req_song_id),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_code_value (rsp_code_value),
      .fail_count     (fail_count),
      .codes_checked  (codes_checked),
      .codes_pending  (codes_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Gap lengths: mostly short, a few long.
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] random_text_byte();
      logic [7:0] corner[4] = '{8'h00, 8'hFF, 8'h7F, 8'h80};
      if ($urandom_range(0, 9) == 0) begin
         return corner[$urandom_range(0, 3)];
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Zero bytes are forced now and then so the shuffle's substitution is hit.
   function automatic logic [31:0] random_song_id();
      logic [31:0] corner[4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
      logic [31:0] id;
      int          pick;
      pick = $urandom_range(0, 9);
      id   = $urandom;
      if (pick == 0) begin
         id = corner[$urandom_range(0, 3)];
      end else if (pick <= 3) begin
         for (int b = 0; b < 4; b++) begin
            if ($urandom_range(0, 1) == 1) begin
               id[b*8 +: 8] = 8'h00;
            end
         end
      end
      return id;
   endfunction

   // Offers one item; returns once taken, at times after an idle gap.
   task automatic send_item(input stach_op_type op, input logic [7:0] text_byte,
                            input logic [31:0] song_id);
      req_valid     <= 1'b1;
      req_mode      <= op;
      req_text_byte <= text_byte;
      req_song_id   <= song_id;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   task automatic send_message(input int n_bytes, input logic [31:0] song_id);
      for (int i = 0; i < n_bytes; i++) begin
         send_item(OP_TEXT, random_text_byte(), $urandom);
      end
      send_item(OP_FINISH, random_text_byte(), song_id);
      messages_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (codes_pending != 0) @(posedge clock);
   endtask

   task automatic random_phase(input int idle_pct, input bit with_hold_off);
      int start_items;
      int pick;
      int n_bytes;
      start_items     = items_sent;
      sender_idle_pct = idle_pct;
      if (with_hold_off) begin
         hold_off_request = 1'b1;
      end
      while (items_sent - start_items < PHASE_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            n_bytes = $urandom_range(0, 12);
         end else if (pick < 95) begin
            n_bytes = $urandom_range(13, 40);
         end else begin
            n_bytes = $urandom_range(41, 100);
         end
         send_message(n_bytes, random_song_id());
      end
      wait_drained();
   endtask

   // Receiver: random stalls and run lengths, plus a long hold-off on request.
   initial begin
      rsp_stall <= 1'b1;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end else begin
            if ($urandom_range(0, 1) == 1) begin
               rsp_stall <= 1'b1;
               repeat (pick_gap()) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 99) < 80) begin
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end else begin
               repeat ($urandom_range(20, 60)) @(posedge clock);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: nothing moved for %0d cycles.", QUIET_LIMIT);
         $display("** song_text_access_code_hash_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      items_sent       = 0;
      messages_sent    = 0;
      sender_idle_pct  = 30;
      hold_off_request = 1'b0;
      quiet_cycles     = 0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_mode      <= OP_TEXT;
      req_text_byte <= 8'h00;
      req_song_id   <= 32'sd0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Empty text with the id extremes; a zero id takes both substitutions.
      send_message(0, 32'h0000_0000);
      send_message(0, 32'hFFFF_FFFF);
      send_message(0, 32'h8000_0000);
      send_message(0, 32'h7FFF_FFFF);
      // Byte extremes, then a zero third byte and a zero top byte.
      send_item(OP_TEXT, 8'h00, 32'hFFFF_FFFF);
      send_item(OP_TEXT, 8'hFF, 32'h0000_0000);
      send_item(OP_TEXT, 8'h7F, 32'h8000_0000);
      send_item(OP_TEXT, 8'h80, 32'h7FFF_FFFF);
      send_item(OP_FINISH, 8'hFF, 32'h1234_5678);
      messages_sent++;
      send_item(OP_TEXT, 8'h01, 32'h0);
      send_item(OP_FINISH, 8'h00, 32'h5A00_C3A5);
      messages_sent++;
      send_message(0, 32'h00AB_1234);
      send_item(OP_TEXT, 8'h80, 32'h0);
      send_item(OP_TEXT, 8'h80, 32'h0);
      send_item(OP_TEXT, 8'h80, 32'h0);
      send_item(OP_FINISH, 8'hA5, 32'hFF00_00FF);
      messages_sent++;
      wait_drained();

      random_phase(0, 1'b0);
      random_phase(40, 1'b1);
      random_phase(0, 1'b0);
      random_phase(20, 1'b0);

      repeat (20) @(posedge clock);
      $display("Run covered %0d items in %0d messages, %0d access codes checked,",
               items_sent, messages_sent, codes_checked);
      $display("with random gaps on both sides and one %0d-cycle receiver hold-off.",
               HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("** song_text_access_code_hash_core: PASSED **");
      end else begin
         $display("** song_text_access_code_hash_core: FAILED **");
      end
      $finish;
   end

endmodule
